@@ sv/bwu_pkg.sv @@
// Package for the breakpoint/watchpoint unit: entry, transfer and control types,
// command and condition codes, opcode decode helpers. No dependencies.
`default_nettype none
package bwu_pkg;
    localparam int NUM_ENTRIES_DEF = 64;

    localparam logic [3:0] CMD_ADD      = 4'd0;
    localparam logic [3:0] CMD_REMOVE   = 4'd1;
    localparam logic [3:0] CMD_SET_EN   = 4'd2;
    localparam logic [3:0] CMD_CHK_EXEC = 4'd3;
    localparam logic [3:0] CMD_CHK_ACC  = 4'd4;
    localparam logic [3:0] CMD_CONTINUE = 4'd5;
    localparam logic [3:0] CMD_STEP_IN  = 4'd6;
    localparam logic [3:0] CMD_STEP_OVR = 4'd7;
    localparam logic [3:0] CMD_STEP_OUT = 4'd8;

    localparam logic [2:0] COND_ALWAYS = 3'd0;
    localparam logic [2:0] COND_EQ     = 3'd1;
    localparam logic [2:0] COND_NE     = 3'd2;
    localparam logic [2:0] COND_GT     = 3'd3;
    localparam logic [2:0] COND_LT     = 3'd4;
    localparam logic [2:0] COND_MASK   = 3'd5;

    localparam logic [2:0] KIND_EXEC   = 3'd0;
    localparam logic [2:0] KIND_MEM_RD = 3'd1;
    localparam logic [2:0] KIND_MEM_WR = 3'd2;
    localparam logic [2:0] KIND_IO_RD  = 3'd3;
    localparam logic [2:0] KIND_IO_WR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;

    localparam logic [7:0] OP_CALL     = 8'hCD;
    localparam logic [7:0] OP_CCALL    = 8'hC4;
    localparam logic [7:0] OP_RST      = 8'hC7;
    localparam logic [7:0] OP_MASK     = 8'hC7;
    localparam logic [7:0] OP_RET      = 8'hC9;
    localparam logic [7:0] OP_CRET     = 8'hC0;
    localparam logic [7:0] OP_PREFIX   = 8'hED;
    localparam logic [7:0] OP_RETI     = 8'h4D;
    localparam logic [15:0] COND_MASK_BITS = 16'hFFFF;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] bp_id;
        logic [2:0]  kind;
        logic [15:0] address;
        logic [2:0]  cond;
        logic [15:0] cond_value;
        logic        enable;
        logic [7:0]  access_value;
        logic [15:0] stack_ptr;
        logic [7:0]  byte_before_pc;
        logic [7:0]  byte_two_before_pc;
        logic [2:0]  instr_len;
    } bwu_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_id;
        logic        stop;
        logic        hit_valid;
        logic [15:0] hit_id;
    } bwu_out_t;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [2:0]  cond;
        logic [15:0] cval;
        logic        en;
    } bwu_entry_t;

    // Lookup broadcast to every cell.
    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [15:0] value;
        logic        scan;
    } bwu_chk_t;

    // Per-cell write strobes.
    typedef struct packed {
        logic load;
        logic set_en;
        logic en_val;
    } bwu_wr_t;

    function automatic logic is_ret(input logic [7:0] b1, input logic [7:0] b2);
        return (b1 == OP_RET) || ((b1 & OP_MASK) == OP_CRET) ||
               (b2 == OP_PREFIX && b1 == OP_RETI);
    endfunction

    function automatic logic is_call(input logic [7:0] op);
        return (op == OP_CALL) || ((op & OP_MASK) == OP_CCALL) ||
               ((op & OP_MASK) == OP_RST);
    endfunction
endpackage
`default_nettype wire

@@ sv/bwu_cell.sv @@
// One table cell: holds a breakpoint entry and compares it against the lookup.
// Depends on bwu_pkg.
`default_nettype none
module bwu_cell (
    input  wire logic               aclk,
    input  wire logic               in_range,
    input  wire bwu_pkg::bwu_chk_t  chk,
    input  wire bwu_pkg::bwu_wr_t   wr,
    input  wire bwu_pkg::bwu_entry_t load_data,
    output bwu_pkg::bwu_entry_t     entry,
    output logic                    id_match,
    output logic                    hit
);
    import bwu_pkg::*;

    bwu_entry_t entry_reg;
    logic       cond_ok;

    always_ff @(posedge aclk) begin
        if (wr.load) begin
            entry_reg <= load_data;
        end else if (wr.set_en) begin
            entry_reg.en <= wr.en_val;
        end
    end

    always_comb begin
        case (entry_reg.cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_EQ:     cond_ok = chk.value == entry_reg.cval;
            COND_NE:     cond_ok = chk.value != entry_reg.cval;
            COND_GT:     cond_ok = chk.value > entry_reg.cval;
            COND_LT:     cond_ok = chk.value < entry_reg.cval;
            COND_MASK:   cond_ok = (chk.value & COND_MASK_BITS) == entry_reg.cval;
            default:     cond_ok = 1'b0;
        endcase
    end

    assign entry    = entry_reg;
    assign id_match = in_range && entry_reg.id == chk.id;
    assign hit      = in_range && chk.scan && entry_reg.en && entry_reg.kind == chk.kind &&
                      entry_reg.addr == chk.addr && cond_ok;
endmodule
`default_nettype wire

@@ sv/breakpoint_watchpoint_unit.sv @@
// Breakpoint/watchpoint unit: a row of NUM_ENTRIES entry cells plus step control.
// A command is captured in S_IDLE; S_MATCH registers the cell compares ahead of the
// first-hit encoder; S_EXEC registers the result, waiting while an untaken result holds
// the output. New commands are taken only in S_IDLE, also while a result waits.
// Reset (aresetn low, synchronous): table empty, next id 1, stepping state cleared.
// Depends on bwu_pkg and bwu_cell.
`default_nettype none
module breakpoint_watchpoint_unit #(
    parameter int NUM_ENTRIES = bwu_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bwu_pkg::bwu_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bwu_pkg::bwu_out_t      m_data
);
    import bwu_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_EXEC} state_t;

    state_t                 state_reg;
    bwu_in_t                item_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [15:0]            next_id_reg;
    logic                   step_active_reg;
    logic [15:0]            step_over_reg;
    logic [15:0]            step_out_reg;
    logic                   m_valid_reg;
    bwu_out_t               m_data_reg;
    logic [NUM_ENTRIES-1:0] idm_vec_reg, hit_vec_reg;

    bwu_chk_t               chk;
    bwu_entry_t             entries [NUM_ENTRIES];
    bwu_wr_t                wr [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] idm_vec, hit_vec;
    bwu_entry_t             new_entry, last_entry, load_data;

    // First matching cell, lowest index wins.
    logic             idm_any, hit_any;
    logic [IDX_W-1:0] idm_idx, hit_idx;
    logic [CNT_W-1:0] last_cnt;
    logic             exec_fire;
    bwu_out_t         res;

    always_comb begin
        chk.id    = item_reg.bp_id;
        chk.addr  = item_reg.address;
        chk.kind  = (item_reg.cmd == CMD_CHK_EXEC) ? KIND_EXEC : item_reg.kind;
        chk.value = (item_reg.cmd == CMD_CHK_EXEC) ? item_reg.address
                                                   : {8'd0, item_reg.access_value};
        chk.scan  = (item_reg.cmd == CMD_CHK_EXEC) ||
                    (item_reg.cmd == CMD_CHK_ACC && item_reg.kind != KIND_EXEC &&
                     item_reg.kind <= KIND_IO_WR);
    end

    always_comb begin
        new_entry.id   = next_id_reg;
        new_entry.kind = item_reg.kind;
        new_entry.addr = item_reg.address;
        new_entry.cond = item_reg.cond;
        new_entry.cval = item_reg.cond_value;
        new_entry.en   = 1'b1;
        last_cnt       = count_reg - CNT_W'(1);
        last_entry     = entries[last_cnt[IDX_W-1:0]];
        load_data      = (item_reg.cmd == CMD_ADD) ? new_entry : last_entry;
    end

    always_comb begin
        idm_any = 1'b0;
        hit_any = 1'b0;
        idm_idx = '0;
        hit_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (idm_vec_reg[i]) begin
                idm_any = 1'b1;
                idm_idx = IDX_W'(i);
            end
            if (hit_vec_reg[i]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    // Write strobes: add fills cell count, remove moves the last entry into the hole.
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            wr[i].load   = 1'b0;
            wr[i].set_en = 1'b0;
            wr[i].en_val = item_reg.enable;
            if (exec_fire) begin
                case (item_reg.cmd)
                    CMD_ADD:
                        wr[i].load = count_reg < CNT_MAX &&
                                     count_reg == CNT_W'(i);
                    CMD_REMOVE:
                        wr[i].load = idm_any && idm_idx == IDX_W'(i) &&
                                     CNT_W'(i) + CNT_W'(1) < count_reg;
                    CMD_SET_EN:
                        wr[i].set_en = idm_any && idm_idx == IDX_W'(i);
                    default: ;
                endcase
            end
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        bwu_cell u_cell (
            .aclk      (aclk),
            .in_range  (CNT_W'(g) < count_reg),
            .chk       (chk),
            .wr        (wr[g]),
            .load_data (load_data),
            .entry     (entries[g]),
            .id_match  (idm_vec[g]),
            .hit       (hit_vec[g])
        );
    end

    // Result of the command held in item_reg.
    always_comb begin
        res = '0;
        case (item_reg.cmd)
            CMD_ADD: begin
                if (count_reg >= CNT_MAX) res.status = ST_FULL;
                else                      res.new_id = next_id_reg;
            end
            CMD_REMOVE, CMD_SET_EN: begin
                if (!idm_any) res.status = ST_NOT_FND;
            end
            CMD_CHK_EXEC, CMD_CHK_ACC: begin
                if (hit_any) begin
                    res.stop      = 1'b1;
                    res.hit_valid = 1'b1;
                    res.hit_id    = entries[hit_idx].id;
                end else if (item_reg.cmd == CMD_CHK_EXEC && step_active_reg) begin
                    if (step_over_reg != 16'd0 && item_reg.address == step_over_reg) begin
                        res.stop = 1'b1;
                    end else if (step_out_reg != 16'd0 && item_reg.stack_ptr > step_out_reg &&
                                 is_ret(item_reg.byte_before_pc, item_reg.byte_two_before_pc)) begin
                        res.stop = 1'b1;
                    end else if (step_over_reg == 16'd0 && step_out_reg == 16'd0) begin
                        res.stop = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            next_id_reg     <= 16'd1;
            step_active_reg <= 1'b0;
            step_over_reg   <= 16'd0;
            step_out_reg    <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Drop the result once taken, unless a new one replaces it this cycle.
            if (m_valid_reg && m_ready && !exec_fire) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    // Latch the cell compares.
                    idm_vec_reg <= idm_vec;
                    hit_vec_reg <= hit_vec;
                    state_reg   <= S_EXEC;
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res;
                        state_reg   <= S_IDLE;
                        case (item_reg.cmd)
                            CMD_ADD: begin
                                if (count_reg < CNT_MAX) begin
                                    count_reg   <= count_reg + CNT_W'(1);
                                    next_id_reg <= next_id_reg + 16'd1;
                                end
                            end
                            CMD_REMOVE: begin
                                if (idm_any) count_reg <= last_cnt;
                            end
                            CMD_CHK_EXEC, CMD_CHK_ACC: begin
                                if (hit_any) begin
                                    step_active_reg <= 1'b1;
                                end else if (item_reg.cmd == CMD_CHK_EXEC && step_active_reg) begin
                                    if (step_over_reg != 16'd0 &&
                                        item_reg.address == step_over_reg) begin
                                        step_over_reg <= 16'd0;
                                    end else if (step_out_reg != 16'd0 &&
                                                 item_reg.stack_ptr > step_out_reg &&
                                                 is_ret(item_reg.byte_before_pc,
                                                        item_reg.byte_two_before_pc)) begin
                                        step_out_reg <= 16'd0;
                                    end
                                end
                            end
                            CMD_CONTINUE: begin
                                step_active_reg <= 1'b0;
                                step_over_reg   <= 16'd0;
                                step_out_reg    <= 16'd0;
                            end
                            CMD_STEP_IN: begin
                                step_active_reg <= 1'b1;
                                step_over_reg   <= 16'd0;
                                step_out_reg    <= 16'd0;
                            end
                            CMD_STEP_OVR: begin
                                step_active_reg <= 1'b1;
                                if (is_call(item_reg.access_value)) begin
                                    step_over_reg <= item_reg.address +
                                                     {13'd0, item_reg.instr_len};
                                end else begin
                                    step_over_reg <= 16'd0;
                                    step_out_reg  <= 16'd0;
                                end
                            end
                            CMD_STEP_OUT: begin
                                step_active_reg <= 1'b1;
                                step_over_reg   <= 16'd0;
                                step_out_reg    <= item_reg.stack_ptr;
                            end
                            default: ;
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX) else $error("entry count above capacity");
    a_hit_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_data_reg.hit_valid || m_data_reg.stop))
        else $error("hit reported without stop");
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_valid_reg && state_reg == S_IDLE)
        else $error("executed command left no result");
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && item_reg.cmd == CMD_ADD && count_reg < CNT_MAX
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the table");
`endif
endmodule
`default_nettype wire
